// ----- design/mcpt_pkg.sv -----
// Shared types and constants of the periodic timer bank.
// Used by every module of the block; depends on nothing.
package mcpt_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CH_BITS      = 4;
    localparam int TIME_BITS    = 48;
    localparam int COUNT_BITS   = 32;
    localparam int STEP_BITS    = $clog2(TIME_BITS);

    localparam logic [CH_BITS-1:0]    CH_LAST   = CH_BITS'(NUM_CHANNELS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Input modes
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_CREATE = 3'd1;
    localparam logic [2:0] MODE_START  = 3'd2;
    localparam logic [2:0] MODE_PAUSE  = 3'd3;
    localparam logic [2:0] MODE_REMOVE = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_FIRED = 2'd0;
    localparam logic [1:0] KIND_QUIET = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;

    typedef struct packed {
        logic [2:0]            mode;
        logic [CH_BITS-1:0]    channel;
        logic [TIME_BITS-1:0]  now_time;
        logic [TIME_BITS-1:0]  start_delay;
        logic [TIME_BITS-1:0]  fire_period;
        logic [COUNT_BITS-1:0] fire_limit;
    } req_word_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [CH_BITS-1:0]    fired_channel;
        logic                  running;
        logic [COUNT_BITS-1:0] times_fired;
        logic                  last;
    } rsp_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_ACK,
        ST_CHK,
        ST_DIV,
        ST_FIRE,
        ST_FLUSH
    } state_t;

endpackage

// ----- design/multi_channel_periodic_timer_core.sv -----
// Top level of the periodic timer bank: channel state, sequencer, result register.
// Depends on mcpt_pkg and mcpt_mod_unit.
//
// Usage: one request word (req) enters when req_valid is high and req_stall low.
// A tick word sets the time and walks the 16 channels in index order; every
// firing channel gives a result word on rsp, the final one of a tick marked
// last. A tick with no firing gives one quiet word. Commands (create, start,
// pause, remove) give one acknowledge word.
// Timing: a command passes the CMD and ACK states before its acknowledge. A tick
// checks each channel in the CHK state; a channel past its first firing also
// waits in DIV for the bit-serial remainder unit, and each firing passes FIRE.
// One request is worked on at a time; req_stall is high until its last word is
// loaded into the result register. The result register holds its word while
// rsp_stall is high, and the walk waits when a further word has to go out.
// Reset clears all channels (not in use, not running, never fired), time 0.
module multi_channel_periodic_timer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  mcpt_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mcpt_pkg::rsp_word_t rsp
);

    localparam int TB = mcpt_pkg::TIME_BITS;
    localparam int CB = mcpt_pkg::COUNT_BITS;
    localparam int NC = mcpt_pkg::NUM_CHANNELS;

    // Channel state
    logic          in_use_reg [NC];
    logic          running_reg [NC];
    logic          never_reg [NC];
    logic          ovf_reg [NC];
    logic [TB-1:0] delay_reg [NC];
    logic [TB-1:0] period_reg [NC];
    logic [CB-1:0] limit_reg [NC];
    logic [CB-1:0] count_reg [NC];
    logic [TB-1:0] start_reg [NC];
    logic [TB-1:0] lastf_reg [NC];

    mcpt_pkg::state_t    state_reg, state_next;
    mcpt_pkg::req_word_t cmd_reg, cmd_next;
    logic [mcpt_pkg::CH_BITS-1:0] addr_reg, addr_next;
    logic [TB-1:0]       now_reg, now_next;
    logic                pend_valid_reg, pend_valid_next;
    mcpt_pkg::rsp_word_t pend_reg, pend_next;
    logic                rsp_valid_reg, rsp_valid_next;
    mcpt_pkg::rsp_word_t rsp_reg, rsp_next;

    logic we_create, we_begin, clr_run, clr_use, we_fire, adv, mod_start, mod_done;
    logic [TB-1:0] mod_rem;
    logic [TB:0]   start_sum;
    logic [TB-1:0] delay_src, local_t, local_l, base;
    logic [TB:0]   target;
    logic          lim_hit, run_eff, due, out_free;
    logic [CB-1:0] new_count;

    // Read the channel at the walk or command address
    always_comb
    begin
        delay_src = (cmd_reg.mode == mcpt_pkg::MODE_CREATE) ? cmd_reg.start_delay
                                                           : delay_reg[addr_reg];
        start_sum = {1'b0, now_reg} + {1'b0, delay_src};
        lim_hit   = (limit_reg[addr_reg] != '0) && (count_reg[addr_reg] >= limit_reg[addr_reg]);
        run_eff   = running_reg[addr_reg] && !lim_hit;
        local_t   = now_reg - start_reg[addr_reg];
        local_l   = (lastf_reg[addr_reg] >= start_reg[addr_reg]) ?
                    lastf_reg[addr_reg] - start_reg[addr_reg] : '0;
        base      = local_l - mod_rem;
        target    = {1'b0, base} + {1'b0, period_reg[addr_reg]};
        due       = {1'b0, local_t} >= target;
        new_count = (count_reg[addr_reg] == mcpt_pkg::COUNT_MAX) ? count_reg[addr_reg]
                                                                 : count_reg[addr_reg] + 1'b1;
        out_free  = !rsp_valid_reg || !rsp_stall;
    end

    mcpt_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (local_l),
        .divisor   (period_reg[addr_reg]),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Sequence commands and the channel walk
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        we_create       = 1'b0;
        we_begin        = 1'b0;
        clr_run         = 1'b0;
        clr_use         = 1'b0;
        we_fire         = 1'b0;
        adv             = 1'b0;
        mod_start       = 1'b0;
        case (state_reg)
            mcpt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next = req;
                    if (req.mode == mcpt_pkg::MODE_TICK)
                    begin
                        now_next        = req.now_time;
                        addr_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = mcpt_pkg::ST_CHK;
                    end
                    else
                    begin
                        addr_next  = req.channel;
                        state_next = mcpt_pkg::ST_CMD;
                    end
                end
            end
            mcpt_pkg::ST_CMD:
            begin
                case (cmd_reg.mode)
                    mcpt_pkg::MODE_CREATE: we_create = 1'b1;
                    mcpt_pkg::MODE_START:  we_begin  = in_use_reg[addr_reg];
                    mcpt_pkg::MODE_PAUSE:  clr_run   = in_use_reg[addr_reg];
                    mcpt_pkg::MODE_REMOVE: clr_use   = in_use_reg[addr_reg];
                    default:               we_begin  = 1'b0;
                endcase
                state_next = mcpt_pkg::ST_ACK;
            end
            mcpt_pkg::ST_ACK:
            begin
                if (out_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.kind          = mcpt_pkg::KIND_ACK;
                    rsp_next.fired_channel = addr_reg;
                    rsp_next.running       = in_use_reg[addr_reg] && running_reg[addr_reg];
                    rsp_next.times_fired   = in_use_reg[addr_reg] ? count_reg[addr_reg] : '0;
                    rsp_next.last          = 1'b1;
                    state_next             = mcpt_pkg::ST_IDLE;
                end
            end
            mcpt_pkg::ST_CHK:
            begin
                if (!in_use_reg[addr_reg])
                    adv = 1'b1;
                else
                begin
                    clr_run = lim_hit;
                    if (!run_eff || ovf_reg[addr_reg] || (now_reg < start_reg[addr_reg]))
                        adv = 1'b1;
                    else if (never_reg[addr_reg])
                        state_next = mcpt_pkg::ST_FIRE;
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = mcpt_pkg::ST_DIV;
                    end
                end
            end
            mcpt_pkg::ST_DIV:
            begin
                if (mod_done)
                begin
                    if (due)
                        state_next = mcpt_pkg::ST_FIRE;
                    else
                        adv = 1'b1;
                end
            end
            mcpt_pkg::ST_FIRE:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    we_fire = 1'b1;
                    if (pend_valid_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = pend_reg;
                    end
                    pend_valid_next         = 1'b1;
                    pend_next.kind          = mcpt_pkg::KIND_FIRED;
                    pend_next.fired_channel = addr_reg;
                    pend_next.running       = running_reg[addr_reg];
                    pend_next.times_fired   = new_count;
                    pend_next.last          = 1'b0;
                    adv                     = 1'b1;
                end
            end
            mcpt_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        rsp_next      = pend_reg;
                        rsp_next.last = 1'b1;
                    end
                    else
                    begin
                        rsp_next.kind          = mcpt_pkg::KIND_QUIET;
                        rsp_next.fired_channel = '0;
                        rsp_next.running       = 1'b0;
                        rsp_next.times_fired   = '0;
                        rsp_next.last          = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = mcpt_pkg::ST_IDLE;
                end
            end
            default:
                state_next = mcpt_pkg::ST_IDLE;
        endcase
        // Advance the walk to the next channel or finish it
        if (adv)
        begin
            if (addr_reg == mcpt_pkg::CH_LAST)
                state_next = mcpt_pkg::ST_FLUSH;
            else
            begin
                addr_next  = addr_reg + 1'b1;
                state_next = mcpt_pkg::ST_CHK;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mcpt_pkg::ST_IDLE;
            addr_reg       <= '0;
            now_reg        <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            now_reg        <= now_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    // Channel flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NC; i++)
            begin
                in_use_reg[i]  <= 1'b0;
                running_reg[i] <= 1'b0;
                never_reg[i]   <= 1'b1;
            end
        end
        else
        begin
            if (we_create)
                in_use_reg[addr_reg] <= 1'b1;
            else if (clr_use)
                in_use_reg[addr_reg] <= 1'b0;
            if (we_create || we_begin)
            begin
                running_reg[addr_reg] <= 1'b1;
                never_reg[addr_reg]   <= 1'b1;
            end
            else if (clr_run || clr_use)
                running_reg[addr_reg] <= 1'b0;
            else if (we_fire)
                never_reg[addr_reg] <= 1'b0;
        end
    end

    // Channel payload
    always_ff @(posedge clk)
    begin
        if (we_create)
        begin
            delay_reg[addr_reg]  <= cmd_reg.start_delay;
            period_reg[addr_reg] <= (cmd_reg.fire_period == '0) ? TB'(1) : cmd_reg.fire_period;
            limit_reg[addr_reg]  <= cmd_reg.fire_limit;
            count_reg[addr_reg]  <= '0;
            lastf_reg[addr_reg]  <= '0;
        end
        else if (we_fire)
        begin
            count_reg[addr_reg] <= new_count;
            lastf_reg[addr_reg] <= now_reg;
        end
        if (we_create || we_begin)
        begin
            start_reg[addr_reg] <= start_sum[TB-1:0];
            ovf_reg[addr_reg]   <= start_sum[TB];
        end
    end

    assign req_stall = (state_reg != mcpt_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    // Quiet and acknowledge words always close their request
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind != mcpt_pkg::KIND_FIRED) |-> rsp.last)
        else $error("non-firing word without last mark");

    // A firing always leaves a nonzero count
    a_fired_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.kind == mcpt_pkg::KIND_FIRED) |-> (rsp.times_fired != '0))
        else $error("firing reported with zero count");

    // An accepted request keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted without going busy");
`endif

endmodule

// ----- design/mcpt_mod_unit.sv -----
// Bit-serial remainder unit: dividend mod divisor, one quotient bit a cycle.
// Depends on mcpt_pkg for the time width.
module mcpt_mod_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mcpt_pkg::TIME_BITS-1:0] dividend,
    input  logic [mcpt_pkg::TIME_BITS-1:0] divisor,
    output logic                           done,
    output logic [mcpt_pkg::TIME_BITS-1:0] remainder
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [mcpt_pkg::STEP_BITS-1:0] step_reg, step_next;
    logic [mcpt_pkg::TIME_BITS-1:0] dvd_reg, dvd_next;
    logic [mcpt_pkg::TIME_BITS-1:0] dvs_reg, dvs_next;
    logic [mcpt_pkg::TIME_BITS:0]   rem_reg, rem_next;
    logic [mcpt_pkg::TIME_BITS:0]   rem_shift;

    // Shift one dividend bit into the partial remainder, subtract when it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        rem_shift = {rem_reg[mcpt_pkg::TIME_BITS-1:0], dvd_reg[mcpt_pkg::TIME_BITS-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[mcpt_pkg::TIME_BITS-2:0], 1'b0};
            if (rem_shift >= {1'b0, dvs_reg})
                rem_next = rem_shift - {1'b0, dvs_reg};
            else
                rem_next = rem_shift;
            step_next = step_reg + 1'b1;
            if (step_reg == mcpt_pkg::STEP_BITS'(mcpt_pkg::TIME_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[mcpt_pkg::TIME_BITS-1:0];

endmodule
